### rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the seven-segment scan driver
// Segment patterns, sequencer states, request kinds and output field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

    // Default number of multiplexed digits
    localparam int DIGIT_COUNT_DEF = 4;

    // Highest number of fraction digits shown
    localparam int MAX_DECIMALS = 3;

    // AND mask that lights the decimal point (active low bit 7)
    localparam logic [7:0] POINT_MASK = 8'h7F;
    localparam logic [7:0] NO_POINT_MASK = 8'hFF;
    localparam logic [7:0] BLANK_PATTERN = 8'hFF;

    // Width of one segment byte and of the digit enable field
    localparam int SEG_W = 8;
    localparam int ENABLE_W = 4;

    // Request kinds carried in s_tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INT,
        ST_FRAC,
        ST_TICK
    } ssd_state_t;

    // Active-low segment pattern of one decimal digit
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'hC0;
            4'd1:    pat = 8'hF9;
            4'd2:    pat = 8'hA4;
            4'd3:    pat = 8'hB0;
            4'd4:    pat = 8'h99;
            4'd5:    pat = 8'h92;
            4'd6:    pat = 8'h82;
            4'd7:    pat = 8'hF8;
            4'd8:    pat = 8'h80;
            4'd9:    pat = 8'h90;
            default: pat = BLANK_PATTERN;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

### rtl/ssd_div10.sv
// ----------------------------------------------------------------------------
// ssd_div10: shared divide-by-ten unit
// Splits a 16-bit value into quotient and last decimal digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssd_div10
(
    input  wire logic [15:0] value,
    output logic      [15:0] quotient,
    output logic      [3:0]  remainder
);

    // 52429 / 2^19 is exact for every 16-bit dividend
    localparam logic [16:0] RECIP = 17'd52429;

    logic [32:0] prod;
    logic [15:0] q_times_ten;
    logic [15:0] diff;

    always_comb
    begin
        prod        = {17'd0, value} * {16'd0, RECIP};
        quotient    = {2'd0, prod[32:19]};
        q_times_ten = (quotient << 3) + (quotient << 1);
        diff        = value - q_times_ten;
        remainder   = diff[3:0];
    end

endmodule

`default_nettype wire

### rtl/ssd_seg_buf.sv
// ----------------------------------------------------------------------------
// ssd_seg_buf: segment byte buffer
// One byte per digit, reset to all segments off; one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssd_seg_buf
#(
    parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF,
    parameter int PW          = $clog2(DIGIT_COUNT)
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [PW-1:0]             wr_addr,
    input  wire logic [ssd_pkg::SEG_W-1:0] wr_data,
    input  wire logic [PW-1:0]             rd_addr,
    output logic      [ssd_pkg::SEG_W-1:0] rd_data
);

    import ssd_pkg::*;

    logic [SEG_W-1:0] buf_reg [DIGIT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                buf_reg[i] <= BLANK_PATTERN;
            end
        end
        else if (wr_en)
        begin
            buf_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = buf_reg[rd_addr];

endmodule

`default_nettype wire

### rtl/seven_segment_mux_driver_top.sv
// ----------------------------------------------------------------------------
// seven_segment_mux_driver_top: multiplexed seven-segment scan driver
// Loads a number into a segment buffer and serializes one digit per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata/s_tuser) takes one request at a
//   time. s_tuser = 0 loads a value: the integer part and fraction value are
//   converted digit by digit into the segment buffer, the point placed by
//   the decimals count, by a shared divide-by-ten unit, one digit per cycle,
//   with no output. s_tuser = 1 is a refresh tick: nine results leave on
//   the master channel (m_tvalid/m_tready/m_tdata/m_tlast), eight shift
//   strobes carrying the scanned byte MSB first with all enables high, then
//   one latch strobe with the scanned digit's enable low and m_tlast set.
//   The tick is registered into the sequencer, which then loads the output
//   register with one result per cycle while m_tready is high; ticks and
//   loads are both run by the single sequencer.
//   s_tready is high only while the sequencer is idle.
//   A stalled receiver holds the current result in the output register and
//   freezes the sequence; nothing is dropped.
//   Reset blanks every buffer byte (all segments off), zeroes the scan
//   position and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_mux_driver_top
#(
    parameter int DIGIT_COUNT = ssd_pkg::DIGIT_COUNT_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] whole_part, [25:16] fraction_value, [28:26] decimals, [31:29] zero
    input  wire logic [31:0] s_tdata,
    // [0] action
    input  wire logic        s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] serial_data, [1] shift_strobe, [2] latch_strobe, [6:3] digit_enables,
    // [7] zero
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    import ssd_pkg::*;

    localparam int PW = $clog2(DIGIT_COUNT);
    localparam logic [PW-1:0] LAST_POS = PW'(DIGIT_COUNT - 1);
    localparam int MAX_D = (DIGIT_COUNT - 1 < MAX_DECIMALS) ? DIGIT_COUNT - 1 : MAX_DECIMALS;
    localparam logic [2:0] MAX_D3 = 3'(MAX_D);
    localparam logic [3:0] LATCH_STEP = 4'd8;

    // request fields
    logic [15:0] in_int;
    logic [9:0]  in_frac;
    logic [2:0]  in_dec;
    logic [2:0]  dec_clamped;
    logic [PW-1:0] point_pos;

    assign in_int  = s_tdata[15:0];
    assign in_frac = s_tdata[25:16];
    assign in_dec  = s_tdata[28:26];

    // sequencer state
    ssd_state_t state_reg, state_next;
    logic [15:0]   val_reg, val_next;
    logic [9:0]    frac_reg, frac_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] point_reg, point_next;
    logic [PW-1:0] scan_reg, scan_next;
    logic [3:0]    step_reg, step_next;
    logic [7:0]    shift_reg, shift_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       sd_reg, sd_next;
    logic       shift_stb_reg, shift_stb_next;
    logic       latch_stb_reg, latch_stb_next;
    logic [3:0] en_reg, en_next;
    logic       last_reg, last_next;

    // shared unit and buffer hookup
    logic [15:0]     div_q;
    logic [3:0]      div_r;
    logic            buf_we;
    logic [PW-1:0]   buf_waddr;
    logic [SEG_W-1:0] buf_wdata;
    logic [SEG_W-1:0] buf_rdata;
    logic [ENABLE_W-1:0] scan_enables;
    logic            accept;
    logic            out_free;

    ssd_div10 u_div10
    (
        .value     (val_reg),
        .quotient  (div_q),
        .remainder (div_r)
    );

    ssd_seg_buf
    #(
        .DIGIT_COUNT (DIGIT_COUNT),
        .PW          (PW)
    )
    u_seg_buf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (buf_we),
        .wr_addr (buf_waddr),
        .wr_data (buf_wdata),
        .rd_addr (scan_reg),
        .rd_data (buf_rdata)
    );

    // clamp decimals, then place the point just left of the fraction
    always_comb
    begin
        dec_clamped = (in_dec > MAX_D3) ? MAX_D3 : in_dec;
        point_pos   = LAST_POS - PW'(dec_clamped);
    end

    // active-low enable of the scanned digit; digits past the port stay high
    always_comb
    begin
        for (int i = 0; i < ENABLE_W; i++)
        begin
            scan_enables[i] = !(int'(scan_reg) == i);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        frac_reg      <= frac_next;
        pos_reg       <= pos_next;
        point_reg     <= point_next;
        step_reg      <= step_next;
        shift_reg     <= shift_next;
        sd_reg        <= sd_next;
        shift_stb_reg <= shift_stb_next;
        latch_stb_reg <= latch_stb_next;
        en_reg        <= en_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        frac_next      = frac_reg;
        pos_next       = pos_reg;
        point_next     = point_reg;
        scan_next      = scan_reg;
        step_next      = step_reg;
        shift_next     = shift_reg;
        out_valid_next = out_valid_reg && !m_tready;
        sd_next        = sd_reg;
        shift_stb_next = shift_stb_reg;
        latch_stb_next = latch_stb_reg;
        en_next        = en_reg;
        last_next      = last_reg;
        buf_we         = 1'b0;
        buf_waddr      = pos_reg;
        buf_wdata      = seg_pattern(div_r);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == ACT_TICK)
                    begin
                        // capture the scanned byte, start the strobe run
                        shift_next = buf_rdata;
                        step_next  = '0;
                        state_next = ST_TICK;
                    end
                    else
                    begin
                        val_next   = in_int;
                        frac_next  = in_frac;
                        pos_next   = point_pos;
                        point_next = point_pos;
                        state_next = ST_INT;
                    end
                end
            end

            ST_INT:
            begin
                // one integer digit per cycle, right to left from the point
                buf_we    = 1'b1;
                buf_wdata = seg_pattern(div_r)
                            & ((pos_reg == point_reg) ? POINT_MASK : NO_POINT_MASK);
                val_next  = div_q;
                if (pos_reg == '0)
                begin
                    if (point_reg != LAST_POS)
                    begin
                        val_next   = {6'd0, frac_reg};
                        pos_next   = LAST_POS;
                        state_next = ST_FRAC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    pos_next = pos_reg - PW'(1);
                end
            end

            ST_FRAC:
            begin
                // fraction digits fill from the rightmost position leftward
                buf_we   = 1'b1;
                val_next = div_q;
                if (pos_reg == point_reg + PW'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg - PW'(1);
                end
            end

            ST_TICK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (step_reg == LATCH_STEP)
                    begin
                        // rotated eight times: bit 0 is back in place
                        sd_next        = shift_reg[0];
                        shift_stb_next = 1'b0;
                        latch_stb_next = 1'b1;
                        en_next        = scan_enables;
                        last_next      = 1'b1;
                        scan_next      = (scan_reg == LAST_POS) ? '0 : scan_reg + PW'(1);
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        sd_next        = shift_reg[7];
                        shift_stb_next = 1'b1;
                        latch_stb_next = 1'b0;
                        en_next        = '1;
                        last_next      = 1'b0;
                        shift_next     = {shift_reg[6:0], shift_reg[7]};
                        step_next      = step_reg + 4'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, en_reg, latch_stb_reg, shift_stb_reg, sd_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

### tb/sv/tb_seven_segment_mux_driver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_mux_driver_top: self-checking bench for the scan driver
// Feeds load and refresh-tick requests into the slave channel and predicts
// every serial beat of each tick. Each beat on the master channel is checked
// field by field against the oldest prediction, under several idle and
// stall mixes on both channels.
// ----------------------------------------------------------------------------

module tb_seven_segment_mux_driver_top;

    import ssd_pkg::*;

    localparam int DIGITS      = DIGIT_COUNT_DEF;
    localparam int IDLE_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 20;     // covers a trailing load pass
    localparam int RANDOM_REQS = 400;
    localparam int PHASE_LEN   = 37;     // accepted requests per idle phase

    // Active-low glyphs of the decimal digits 0..9, digit 0 in the low byte
    localparam logic [9:0][7:0] GLYPHS = {
        8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    // One request for the slave channel
    typedef struct {
        logic        action;
        logic [15:0] whole_part;
        logic [9:0]  fraction_value;
        logic [2:0]  decimals;
    } display_req_t;

    // Layout of m_tdata, lowest bit last in the list
    typedef struct packed {
        logic       pad;
        logic [3:0] digit_enables;
        logic       latch_strobe;
        logic       shift_strobe;
        logic       serial_data;
    } scan_beat_t;

    typedef struct packed {
        logic       tlast;
        scan_beat_t beat;
    } scan_result_t;

    // ------------------------------------------------------------------
    // Block under test and its drive signals
    // ------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] whole_part, [25:16] fraction_value, [28:26] decimals, [31:29] zero
    logic [31:0] s_tdata  = '0;
    // [0] action
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] serial_data, [1] shift_strobe, [2] latch_strobe, [6:3] digit_enables,
    // [7] zero
    logic [7:0]  m_tdata;
    logic        m_tlast;

    seven_segment_mux_driver_top #(
        .DIGIT_COUNT (DIGITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    display_req_t pending_reqs[$];     // requests not yet offered
    scan_result_t expected_beats[$];   // predicted beats not yet seen
    display_req_t next_req;

    // Own copy of the display buffer and the scan counter
    logic [7:0]   shown_bytes [DIGITS];
    int           scan_digit;

    int           error_count   = 0;
    int           accepted_reqs = 0;
    int           idle_cycles   = 0;
    int           idle_phase;
    logic         timed_out;

    // Idle mix: none, sender idles, receiver stalls, both lightly
    assign idle_phase = (accepted_reqs / PHASE_LEN) % 4;
    assign timed_out  = (idle_cycles >= IDLE_LIMIT);

    function automatic int sender_idle_pct(input int phase);
        return (phase == 1) ? 57 : (phase == 3) ? 7 : 0;
    endfunction

    function automatic int receiver_stall_pct(input int phase);
        return (phase == 2) ? 57 : (phase == 3) ? 7 : 0;
    endfunction

    // Glyph of decimal digit k (0 = units) of a value
    function automatic logic [7:0] digit_glyph(input int unsigned value, input int k);
        int unsigned v;
        v = value;
        for (int i = 0; i < k; i++)
            v = v / 10;
        return GLYPHS[v % 10];
    endfunction

    // ------------------------------------------------------------------
    // Display predictor: update the buffer on a load, queue nine beats on
    // a tick
    // ------------------------------------------------------------------
    task automatic predict_display(input logic action, input logic [15:0] int_part,
                                   input logic [9:0] frac_part, input logic [2:0] dec);
        int           places;
        int           point_pos;
        logic [7:0]   scanned;
        scan_result_t res;
        places = int'(dec);
        if (action == ACT_LOAD)
        begin
            // Clamp the fraction width, then place integer digits right-aligned
            if (places > MAX_DECIMALS)
                places = MAX_DECIMALS;
            if (places > DIGITS - 1)
                places = DIGITS - 1;
            point_pos = DIGITS - 1 - places;
            for (int i = 0; i <= point_pos; i++)
                shown_bytes[point_pos - i] = digit_glyph(32'(int_part), i);
            // Light the point on the last integer digit
            shown_bytes[point_pos] = shown_bytes[point_pos] & POINT_MASK;
            for (int i = 0; i < places; i++)
                shown_bytes[DIGITS - 1 - i] = digit_glyph(32'(frac_part), i);
        end
        else
        begin
            scanned = shown_bytes[scan_digit];
            // Eight shift beats, MSB first, all enables blanked
            for (int k = 0; k < 8; k++)
            begin
                res.tlast              = 1'b0;
                res.beat.pad           = 1'b0;
                res.beat.digit_enables = 4'hF;
                res.beat.latch_strobe  = 1'b0;
                res.beat.shift_strobe  = 1'b1;
                res.beat.serial_data   = scanned[7 - k];
                expected_beats.push_back(res);
            end
            // Latch beat drives the scanned digit low
            res.tlast              = 1'b1;
            res.beat.digit_enables = ~(4'b0001 << scan_digit);
            res.beat.latch_strobe  = 1'b1;
            res.beat.shift_strobe  = 1'b0;
            res.beat.serial_data   = scanned[0];
            expected_beats.push_back(res);
            scan_digit = (scan_digit + 1) % DIGITS;
        end
    endtask

    task automatic push_request(input logic action, input logic [15:0] int_part,
                                input logic [9:0] frac_part, input logic [2:0] dec);
        display_req_t req;
        req.action         = action;
        req.whole_part     = int_part;
        req.fraction_value = frac_part;
        req.decimals       = dec;
        pending_reqs.push_back(req);
    endtask

    // Tick with junk in the data fields, which the block ignores on a tick
    task automatic push_tick();
        push_request(ACT_TICK, 16'($urandom), 10'($urandom_range(1023)),
                     3'($urandom_range(7)));
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next pending request, hold it until taken.
    // Predict from the port values at the edge where the request is taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_display(s_tuser, s_tdata[15:0], s_tdata[25:16], s_tdata[28:26]);
                accepted_reqs <= accepted_reqs + 1;
            end
            // Advance only when nothing is held or the held request was taken
            if (!s_tvalid || s_tready)
            begin
                if (pending_reqs.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct(idle_phase))
                begin
                    next_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_req.action;
                    s_tdata  <= {3'b000, next_req.decimals, next_req.fraction_value,
                                 next_req.whole_part};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each taken beat against the oldest prediction, then
    // pick the ready level for the next cycle
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        scan_result_t want;
        scan_beat_t   got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_beats.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, %s %0h tlast %0b",
                             $time, "actual tdata", m_tdata, m_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("serial_data", 8'(want.beat.serial_data),
                                8'(got.serial_data));
                    check_field("shift_strobe", 8'(want.beat.shift_strobe),
                                8'(got.shift_strobe));
                    check_field("latch_strobe", 8'(want.beat.latch_strobe),
                                8'(got.latch_strobe));
                    check_field("digit_enables", 8'(want.beat.digit_enables),
                                8'(got.digit_enables));
                    check_field("tdata pad", 8'(want.beat.pad), 8'(got.pad));
                    check_field("tlast", 8'(want.tlast), 8'(m_tlast));
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct(idle_phase));
        end
    end

    // Watchdog: count cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < DIGITS; i++)
            shown_bytes[i] = BLANK_PATTERN;
        scan_digit = 0;

        // Scan the blank buffer once after reset
        repeat (DIGITS) push_tick();
        // Widest values: integer digits above the units and fraction digits
        // above 999 drop, decimals above three clamp
        push_request(ACT_LOAD, 16'hFFFF, 10'h3FF, 3'd7);
        repeat (DIGITS) push_tick();
        // All zero, no fraction: point on the rightmost digit
        push_request(ACT_LOAD, 16'd0, 10'd0, 3'd0);
        repeat (DIGITS) push_tick();
        // Full three-digit fraction, single integer digit kept
        push_request(ACT_LOAD, 16'd9999, 10'd999, 3'd3);
        repeat (DIGITS) push_tick();
        // One decimal place
        push_request(ACT_LOAD, 16'd1234, 10'd5, 3'd1);
        repeat (DIGITS) push_tick();

        // Random mix: mostly ticks, loads spread over small and full ranges
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if ($urandom_range(3) == 0)
                push_request(ACT_LOAD,
                             $urandom_range(1) ? 16'($urandom_range(65535))
                                               : 16'($urandom_range(99)),
                             10'($urandom_range(1023)), 3'($urandom_range(7)));
            else
                push_tick();
        end

        // Hold reset, then release it at an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: everything offered and taken, every beat seen
        while (!timed_out && (pending_reqs.size() != 0 || s_tvalid ||
                              expected_beats.size() != 0))
            @(negedge clk);
        // Let a trailing load pass finish and catch stray beats
        if (!timed_out)
            repeat (DRAIN_WAIT) @(negedge clk);

        if (expected_beats.size() != 0)
        begin
            $display("%0t ns: %0d results missing, expected tdata %0h, actual none",
                     $time, expected_beats.size(), expected_beats[0].beat);
            error_count++;
        end

        if (!timed_out && error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### seven_segment_mux_driver_top.f
rtl/ssd_pkg.sv
rtl/ssd_div10.sv
rtl/ssd_seg_buf.sv
rtl/seven_segment_mux_driver_top.sv
tb/sv/tb_seven_segment_mux_driver_top.sv
